// ----- rtl/core/fss_pkg.sv -----
// Shared types and constants for the fan speed step selector.
`default_nettype none

package fss_pkg;

    localparam int SPEED_W = 7;
    localparam int STEP_W  = 3;
    localparam int REQ_W   = 8;
    localparam int IDX_W   = 3;

    localparam logic [SPEED_W-1:0] SPEED_MAX = 7'd100;
    localparam logic [SPEED_W-1:0] BEST_INIT = 7'd127;

    typedef logic [SPEED_W-1:0] t_speed;
    typedef logic [STEP_W-1:0]  t_step;

    typedef enum logic [1:0] {
        OP_DOWN = 2'd0,
        OP_UP   = 2'd1,
        OP_SET  = 2'd2,
        OP_STOP = 2'd3
    } t_op;

    // table lookup result for one step
    typedef struct packed {
        t_speed speed;    // speed for the addressed step
        logic   word_nz;  // table word behind the step is nonzero
    } t_table_rd;

    // compare unit result
    typedef struct packed {
        t_speed diff;     // |a - b|
        logic   lt_best;  // diff below running best
        logic   equal;    // a == b
    } t_cmp_res;

endpackage

`default_nettype wire

// ----- rtl/core/fan_speed_step_selector_core.sv -----
// Top level of the fan speed step selector: sequencer, state and stream ports.
// Sequence: an accepted stop goes through EXEC and DONE; down/up go through EXEC, FOLLOW
//   and DONE; set goes through EXEC, then scans one table step per cycle in SCAN
//   through the shared compare unit, then DONE; the result is registered on leaving DONE.
// Throughput: one transaction at a time; the input is ready only while idle, in the
//   cycle after the result is registered; a full output register holds the sequencer.
// Reset: synchronous, active low; step, drive, table words and handshake state clear.
`default_nettype none

module fan_speed_step_selector_core #(
    parameter int TABLE_WORDS = 6
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // config port
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_idx,
    input  wire  [6:0]  i_cfg_data,
    // input stream
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [7:0]  i_s_tdata,   // [7:0] requested_speed (signed)
    input  wire  [1:0]  i_s_tuser,   // [1:0] op
    // result stream
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [15:0] o_m_tdata    // [6:0] drive_speed, [9:7] speed_step,
                                     // [10] update_event, [15:11] zero
);
    import fss_pkg::*;

    localparam t_step LAST_STEP = STEP_W'(TABLE_WORDS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FOLLOW,
        S_DONE
    } t_state;

    t_state    r_state;
    t_op       r_op;
    t_speed    r_req;      // clamped request
    t_step     r_step;
    t_speed    r_drive;
    t_speed    r_best;
    t_step     r_idx;      // scan position
    logic      r_ev;
    logic      r_out_valid;
    logic [15:0] r_out_data;

    t_step     tbl_addr;
    t_table_rd tbl_rd;
    t_speed    cmp_b;
    t_cmp_res  cmp_res;
    t_speed    req_clamped;
    logic      in_acc;
    logic      out_free;

    // one table read port and one compare unit serve every state
    assign tbl_addr = (r_state == S_SCAN) ? r_idx : r_step;
    assign cmp_b    = (r_state == S_SCAN) ? r_req : r_drive;

    fss_step_table #(
        .TABLE_WORDS (TABLE_WORDS)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_step     (tbl_addr),
        .o_rd       (tbl_rd)
    );

    fss_cmp_unit u_cmp (
        .i_a    (tbl_rd.speed),
        .i_b    (cmp_b),
        .i_best (r_best),
        .o_res  (cmp_res)
    );

    // negative requests go to 0, anything above full speed to full speed
    always_comb begin
        if (i_s_tdata[7]) begin
            req_clamped = '0;
        end else if (i_s_tdata[6:0] > SPEED_MAX) begin
            req_clamped = SPEED_MAX;
        end else begin
            req_clamped = i_s_tdata[6:0];
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_drive     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a new result takes the register as the old one leaves
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op    <= t_op'(i_s_tuser);
                        r_req   <= req_clamped;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (r_op)
                        OP_DOWN: begin
                            if (r_step != '0) begin
                                r_step <= r_step - 1'b1;
                            end
                            r_state <= S_FOLLOW;
                        end
                        OP_UP: begin
                            // word_nz is low for steps outside the table
                            if (r_step == '0 || tbl_rd.word_nz) begin
                                r_step <= r_step + 1'b1;
                            end
                            r_state <= S_FOLLOW;
                        end
                        OP_SET: begin
                            r_drive <= r_req;
                            r_best  <= BEST_INIT;
                            r_idx   <= '0;
                            r_state <= S_SCAN;
                        end
                        default: begin
                            r_step  <= '0;
                            r_drive <= '0;
                            r_ev    <= 1'b1;
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_SCAN: begin
                    // nearest step, earliest wins on ties; stop at full speed
                    if (cmp_res.lt_best) begin
                        r_best <= cmp_res.diff;
                        r_step <= r_idx;
                    end
                    if (tbl_rd.speed == SPEED_MAX) begin
                        r_ev    <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_FOLLOW: begin
                    r_ev <= !cmp_res.equal;
                    if (!cmp_res.equal) begin
                        r_drive <= tbl_rd.speed;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_data  <= {5'b0, r_ev, r_step, r_drive};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // step can only climb one past the table
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= LAST_STEP)
        else $error("step beyond table end");

    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drive <= SPEED_MAX)
        else $error("drive above full speed");

    // scan always ends by the step past the table, which reads full speed
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_op == OP_SET && r_idx <= LAST_STEP))
        else $error("scan ran past last step");

    // a stop result carries zero step and drive with an update
    a_stop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free && r_op == OP_STOP)
        |=> (o_m_tdata[10:0] == {1'b1, 3'd0, 7'd0}))
        else $error("stop result not cleared");

endmodule

`default_nettype wire

// ----- rtl/core/fss_step_table.sv -----
// Step speed table: configuration words and the step to speed lookup.
`default_nettype none

module fss_step_table #(
    parameter int TABLE_WORDS = 6
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire  [fss_pkg::IDX_W-1:0]    i_cfg_idx,
    input  wire  fss_pkg::t_speed        i_cfg_data,
    input  wire  fss_pkg::t_step         i_step,
    output fss_pkg::t_table_rd           o_rd
);
    import fss_pkg::*;

    logic [SPEED_W-1:0] r_word [TABLE_WORDS];

    // words outside the table are never consulted, so not stored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TABLE_WORDS; k++) begin
                r_word[k] <= '0;
            end
        end else begin
            for (int k = 0; k < TABLE_WORDS; k++) begin
                if (i_cfg_we && (i_cfg_idx == IDX_W'(k))) begin
                    r_word[k] <= i_cfg_data;
                end
            end
        end
    end

    always_comb begin
        t_speed w;
        w = '0;
        for (int k = 0; k < TABLE_WORDS; k++) begin
            if (i_step == STEP_W'(k + 1)) begin
                w = r_word[k];
            end
        end
        o_rd.word_nz = (w != '0);
        if (i_step == '0) begin
            o_rd.speed = '0;
        end else if (w == '0 || w > SPEED_MAX) begin
            o_rd.speed = SPEED_MAX;
        end else begin
            o_rd.speed = w;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/fss_cmp_unit.sv -----
// Shared compare unit: absolute difference, best compare and equality.
`default_nettype none

module fss_cmp_unit (
    input  wire  fss_pkg::t_speed  i_a,
    input  wire  fss_pkg::t_speed  i_b,
    input  wire  fss_pkg::t_speed  i_best,
    output fss_pkg::t_cmp_res      o_res
);
    import fss_pkg::*;

    always_comb begin
        if (i_a >= i_b) begin
            o_res.diff = i_a - i_b;
        end else begin
            o_res.diff = i_b - i_a;
        end
        o_res.lt_best = (o_res.diff < i_best);
        o_res.equal   = (i_a == i_b);
    end

endmodule

`default_nettype wire
